// ===== sv/ncc_pkg.sv =====
// Shared constants and types for the nearest centroid clusterer.
// No dependencies; every other file imports this package.
package ncc_pkg;

  localparam int unsigned CntW      = 16;
  localparam int unsigned ThrW      = 34;
  localparam logic [ThrW-1:0] ThrReset = 34'd14745600;
  localparam logic [CntW-1:0] CntMax   = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== sv/ncc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends only on ncc_pkg.
module ncc_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  import ncc_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/ncc_cell.sv =====
// One cluster cell of the scan chain: holds one centroid and count, and
// compares the passing point against it over two register stages. Uses ncc_pkg.
module ncc_cell #(
  parameter int unsigned CB       = 16,
  parameter int unsigned IDX_W    = 5,
  parameter int unsigned IU_W     = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [IU_W-1:0]          in_use_i,
  input  logic                     valid_i,
  input  logic [CB-1:0]            px_i,
  input  logic [CB-1:0]            py_i,
  input  logic [CB-1:0]            pz_i,
  input  logic                     found_i,
  input  logic [2*CB+1:0]          best_i,
  input  logic [IDX_W-1:0]         bidx_i,
  input  logic [CB-1:0]            bcx_i,
  input  logic [CB-1:0]            bcy_i,
  input  logic [CB-1:0]            bcz_i,
  input  logic [ncc_pkg::CntW-1:0] bcnt_i,
  output logic                     valid_o,
  output logic [CB-1:0]            px_o,
  output logic [CB-1:0]            py_o,
  output logic [CB-1:0]            pz_o,
  output logic                     found_o,
  output logic [2*CB+1:0]          best_o,
  output logic [IDX_W-1:0]         bidx_o,
  output logic [CB-1:0]            bcx_o,
  output logic [CB-1:0]            bcy_o,
  output logic [CB-1:0]            bcz_o,
  output logic [ncc_pkg::CntW-1:0] bcnt_o,
  input  logic                     wr_en_i,
  input  logic [IDX_W-1:0]         wr_idx_i,
  input  logic [CB-1:0]            wr_cx_i,
  input  logic [CB-1:0]            wr_cy_i,
  input  logic [CB-1:0]            wr_cz_i,
  input  logic [ncc_pkg::CntW-1:0] wr_cnt_i
);
  import ncc_pkg::*;

  localparam int unsigned DW = 2 * CB + 2;

  logic [CB-1:0]   cx_q, cy_q, cz_q;
  logic [CntW-1:0] cnt_q;
  logic [CB-1:0]   dx, dy, dz;

  logic            a_valid_q;
  logic [CB-1:0]   a_px_q, a_py_q, a_pz_q;
  logic            a_found_q;
  logic [DW-1:0]   a_best_q;
  logic [IDX_W-1:0] a_bidx_q;
  logic [CB-1:0]   a_bcx_q, a_bcy_q, a_bcz_q;
  logic [CntW-1:0] a_bcnt_q;
  logic [2*CB-1:0] sqx_q, sqy_q, sqz_q;

  logic [DW-1:0]   dist_sum;
  logic            take;

  logic            b_valid_q;
  logic [CB-1:0]   b_px_q, b_py_q, b_pz_q;
  logic            b_found_q;
  logic [DW-1:0]   b_best_q;
  logic [IDX_W-1:0] b_bidx_q;
  logic [CB-1:0]   b_bcx_q, b_bcy_q, b_bcz_q;
  logic [CntW-1:0] b_bcnt_q;

  assign dx = (px_i > cx_q) ? px_i - cx_q : cx_q - px_i;
  assign dy = (py_i > cy_q) ? py_i - cy_q : cy_q - py_i;
  assign dz = (pz_i > cz_q) ? pz_i - cz_q : cz_q - pz_i;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IDX_W'(CELL_IDX))) begin
      cx_q  <= wr_cx_i;
      cy_q  <= wr_cy_i;
      cz_q  <= wr_cz_i;
      cnt_q <= wr_cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_px_q   <= px_i;
    a_py_q   <= py_i;
    a_pz_q   <= pz_i;
    a_found_q <= found_i;
    a_best_q <= best_i;
    a_bidx_q <= bidx_i;
    a_bcx_q  <= bcx_i;
    a_bcy_q  <= bcy_i;
    a_bcz_q  <= bcz_i;
    a_bcnt_q <= bcnt_i;
    sqx_q    <= (2*CB)'(dx) * (2*CB)'(dx);
    sqy_q    <= (2*CB)'(dy) * (2*CB)'(dy);
    sqz_q    <= (2*CB)'(dz) * (2*CB)'(dz);
  end

  assign dist_sum = DW'(sqx_q) + DW'(sqy_q) + DW'(sqz_q);
  assign take = (IU_W'(CELL_IDX) < in_use_i) && (!a_found_q || (dist_sum < a_best_q));

  always_ff @(posedge clk_i) begin
    b_px_q    <= a_px_q;
    b_py_q    <= a_py_q;
    b_pz_q    <= a_pz_q;
    b_found_q <= a_found_q || take;
    b_best_q  <= take ? dist_sum : a_best_q;
    b_bidx_q  <= take ? IDX_W'(CELL_IDX) : a_bidx_q;
    b_bcx_q   <= take ? cx_q : a_bcx_q;
    b_bcy_q   <= take ? cy_q : a_bcy_q;
    b_bcz_q   <= take ? cz_q : a_bcz_q;
    b_bcnt_q  <= take ? cnt_q : a_bcnt_q;
  end

  assign valid_o = b_valid_q;
  assign px_o    = b_px_q;
  assign py_o    = b_py_q;
  assign pz_o    = b_pz_q;
  assign found_o = b_found_q;
  assign best_o  = b_best_q;
  assign bidx_o  = b_bidx_q;
  assign bcx_o   = b_bcx_q;
  assign bcy_o   = b_bcy_q;
  assign bcz_o   = b_bcz_q;
  assign bcnt_o  = b_bcnt_q;

endmodule

// ===== sv/nearest_centroid_clusterer.sv =====
// Nearest centroid clusterer top level: scan chain, decision, running mean.
// Depends on ncc_pkg, ncc_cell and ncc_div.
//
// Points arrive on the slave stream: tdata carries pos_x, pos_y, pos_z from
// the lowest bit up, and tuser carries clear_first. Each result word leaves
// on the master stream: tdata carries cluster_index, centroid_x, centroid_y,
// centroid_z, member_count from the lowest bit up; tuser carries created in
// bit 0 and dropped in bit 1.
// One point is worked on at a time. Its scan walks a chain of MAX_CLUSTERS
// cells through the two register stages of each cell, and the decision
// follows. A point that opens a cluster or is dropped then presents its
// result; a point that joins a cluster first passes the multiply state
// and the three parallel dividers. The next point can be taken in the
// same cycle that the result is presented.
// The result register decouples the two sides: a new point is taken while
// the previous result still waits, and a finished result waits for the
// receiver to take the old one. Reset empties the table and loads the
// default join distance; the join distance is written through cfg_wr_en_i.
module nearest_centroid_clusterer #(
  parameter int unsigned MAX_CLUSTERS = 32,
  parameter int unsigned COORD_BITS   = 16,
  localparam int unsigned IDX_W       = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int unsigned IN_W        = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W       = ((IDX_W + 3 * COORD_BITS + 16 + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_wr_en_i,
  input  logic [ncc_pkg::ThrW-1:0] cfg_wr_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_W-1:0]          s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic                     s_axis_tuser,   // clear_first
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_W-1:0]         m_axis_tdata,   // cluster_index, centroid_x/y/z, member_count
  output logic [1:0]               m_axis_tuser    // created, dropped
);
  import ncc_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned DW    = 2 * CB + 2;
  localparam int unsigned IU_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned CMP_W = (DW > ThrW) ? DW : ThrW;
  localparam int unsigned NUM_W = 2 * CB;

  state_e state_q, state_d;

  logic [ThrW-1:0] thr_q;
  logic [IU_W-1:0] in_use_q;
  logic            inj_q;
  logic [CB-1:0]   px_q, py_q, pz_q;

  logic            fin_found_q;
  logic [DW-1:0]   fin_best_q;
  logic [IDX_W-1:0] fin_idx_q;
  logic [CB-1:0]   fin_cx_q, fin_cy_q, fin_cz_q;
  logic [CntW-1:0] fin_cnt_q;

  logic [CntW-1:0] n_q;
  logic [NUM_W-1:0] nx_q, ny_q, nz_q;

  logic [IDX_W-1:0] res_idx_q;
  logic            res_created_q, res_dropped_q;
  logic [CB-1:0]   res_cx_q, res_cy_q, res_cz_q;
  logic [CntW-1:0] res_cnt_q;

  logic            out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic [1:0]      out_user_q;

  logic            accept, far, room, create, out_free;
  logic [CntW-1:0] n_calc;
  logic            div_start;
  logic            dx_done, dy_done, dz_done;
  logic [NUM_W-1:0] qx, qy, qz;
  logic            wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [CB-1:0]   wr_cx, wr_cy, wr_cz;
  logic [CntW-1:0] wr_cnt;

  logic            ch_valid [MAX_CLUSTERS+1];
  logic [CB-1:0]   ch_px    [MAX_CLUSTERS+1];
  logic [CB-1:0]   ch_py    [MAX_CLUSTERS+1];
  logic [CB-1:0]   ch_pz    [MAX_CLUSTERS+1];
  logic            ch_found [MAX_CLUSTERS+1];
  logic [DW-1:0]   ch_best  [MAX_CLUSTERS+1];
  logic [IDX_W-1:0] ch_bidx [MAX_CLUSTERS+1];
  logic [CB-1:0]   ch_bcx   [MAX_CLUSTERS+1];
  logic [CB-1:0]   ch_bcy   [MAX_CLUSTERS+1];
  logic [CB-1:0]   ch_bcz   [MAX_CLUSTERS+1];
  logic [CntW-1:0] ch_bcnt  [MAX_CLUSTERS+1];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign far      = !fin_found_q || (CMP_W'(fin_best_q) > CMP_W'(thr_q));
  assign room     = (in_use_q < IU_W'(MAX_CLUSTERS));
  assign create   = far && room;
  assign out_free = !out_valid_q || m_axis_tready;
  assign n_calc   = (fin_cnt_q == CntMax) ? CntMax :
                    ((fin_cnt_q < CntW'(1)) ? CntW'(2) : fin_cnt_q + 1'b1);

  assign ch_valid[0] = inj_q;
  assign ch_px[0]    = px_q;
  assign ch_py[0]    = py_q;
  assign ch_pz[0]    = pz_q;
  assign ch_found[0] = 1'b0;
  assign ch_best[0]  = '0;
  assign ch_bidx[0]  = '0;
  assign ch_bcx[0]   = '0;
  assign ch_bcy[0]   = '0;
  assign ch_bcz[0]   = '0;
  assign ch_bcnt[0]  = '0;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    ncc_cell #(
      .CB       (CB),
      .IDX_W    (IDX_W),
      .IU_W     (IU_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .in_use_i (in_use_q),
      .valid_i  (ch_valid[g]),
      .px_i     (ch_px[g]),
      .py_i     (ch_py[g]),
      .pz_i     (ch_pz[g]),
      .found_i  (ch_found[g]),
      .best_i   (ch_best[g]),
      .bidx_i   (ch_bidx[g]),
      .bcx_i    (ch_bcx[g]),
      .bcy_i    (ch_bcy[g]),
      .bcz_i    (ch_bcz[g]),
      .bcnt_i   (ch_bcnt[g]),
      .valid_o  (ch_valid[g+1]),
      .px_o     (ch_px[g+1]),
      .py_o     (ch_py[g+1]),
      .pz_o     (ch_pz[g+1]),
      .found_o  (ch_found[g+1]),
      .best_o   (ch_best[g+1]),
      .bidx_o   (ch_bidx[g+1]),
      .bcx_o    (ch_bcx[g+1]),
      .bcy_o    (ch_bcy[g+1]),
      .bcz_o    (ch_bcz[g+1]),
      .bcnt_o   (ch_bcnt[g+1]),
      .wr_en_i  (wr_en),
      .wr_idx_i (wr_idx),
      .wr_cx_i  (wr_cx),
      .wr_cy_i  (wr_cy),
      .wr_cz_i  (wr_cz),
      .wr_cnt_i (wr_cnt)
    );
  end

  ncc_div #(.NUM_W(NUM_W), .DEN_W(CntW)) u_div_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (nx_q), .den_i (n_q), .done_o (dx_done), .quo_o (qx)
  );
  ncc_div #(.NUM_W(NUM_W), .DEN_W(CntW)) u_div_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (ny_q), .den_i (n_q), .done_o (dy_done), .quo_o (qy)
  );
  ncc_div #(.NUM_W(NUM_W), .DEN_W(CntW)) u_div_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (nz_q), .den_i (n_q), .done_o (dz_done), .quo_o (qz)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   if (ch_valid[MAX_CLUSTERS]) state_d = ST_DECIDE;
      ST_DECIDE: state_d = far ? ST_DONE : ST_MUL;
      ST_MUL:    state_d = ST_DIVGO;
      ST_DIVGO:  state_d = ST_DIV;
      ST_DIV:    if (dx_done && dy_done && dz_done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    div_start     = (state_q == ST_DIVGO);
    wr_en         = 1'b0;
    wr_idx        = fin_idx_q;
    wr_cx         = CB'(qx);
    wr_cy         = CB'(qy);
    wr_cz         = CB'(qz);
    wr_cnt        = n_q;
    unique case (state_q)
      ST_DECIDE: begin
        wr_en  = create;
        wr_idx = in_use_q[IDX_W-1:0];
        wr_cx  = px_q;
        wr_cy  = py_q;
        wr_cz  = pz_q;
        wr_cnt = CntW'(1);
      end
      ST_DIV: begin
        wr_en = dx_done && dy_done && dz_done;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= ThrReset;
      in_use_q    <= '0;
      inj_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= accept;
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
      if (accept && s_axis_tuser) begin
        in_use_q <= '0;
      end else if (state_q == ST_DECIDE && create) begin
        in_use_q <= in_use_q + 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= s_axis_tdata[CB-1:0];
      py_q <= s_axis_tdata[2*CB-1:CB];
      pz_q <= s_axis_tdata[3*CB-1:2*CB];
    end
    if (state_q == ST_SCAN && ch_valid[MAX_CLUSTERS]) begin
      fin_found_q <= ch_found[MAX_CLUSTERS];
      fin_best_q  <= ch_best[MAX_CLUSTERS];
      fin_idx_q   <= ch_bidx[MAX_CLUSTERS];
      fin_cx_q    <= ch_bcx[MAX_CLUSTERS];
      fin_cy_q    <= ch_bcy[MAX_CLUSTERS];
      fin_cz_q    <= ch_bcz[MAX_CLUSTERS];
      fin_cnt_q   <= ch_bcnt[MAX_CLUSTERS];
    end
    if (state_q == ST_DECIDE) begin
      n_q           <= n_calc;
      res_idx_q     <= create ? in_use_q[IDX_W-1:0] : (far ? '0 : fin_idx_q);
      res_created_q <= create;
      res_dropped_q <= far && !room;
      res_cx_q      <= create ? px_q : '0;
      res_cy_q      <= create ? py_q : '0;
      res_cz_q      <= create ? pz_q : '0;
      res_cnt_q     <= create ? CntW'(1) : '0;
    end
    if (state_q == ST_MUL) begin
      nx_q <= NUM_W'(fin_cx_q) * NUM_W'(n_q - 1'b1) + NUM_W'(px_q);
      ny_q <= NUM_W'(fin_cy_q) * NUM_W'(n_q - 1'b1) + NUM_W'(py_q);
      nz_q <= NUM_W'(fin_cz_q) * NUM_W'(n_q - 1'b1) + NUM_W'(pz_q);
    end
    if (state_q == ST_DIV && dx_done && dy_done && dz_done) begin
      res_cx_q  <= CB'(qx);
      res_cy_q  <= CB'(qy);
      res_cz_q  <= CB'(qz);
      res_cnt_q <= n_q;
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= OUT_W'({res_cnt_q, res_cz_q, res_cy_q, res_cx_q, res_idx_q});
      out_user_q <= {res_dropped_q, res_created_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_in_use_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use_q <= IU_W'(MAX_CLUSTERS))
    else $error("cluster count exceeds table size");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_DECIDE || state_q == ST_DIV))
    else $error("cell write outside decision or divide");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN && inj_q))
    else $error("accepted point did not start a scan");

  a_drop_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_user_q[0] && out_user_q[1]))
    else $error("result both created and dropped");

endmodule
